// ===== sv/ipdp_pkg.sv =====
// Shared types and constants for the dotted-decimal IPv4 text parser.
package ipdp_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_DOT  = 8'h2E;

  localparam int unsigned OCTET_MAX   = 255;
  localparam int unsigned MAX_COMP    = 4;
  // only the first three components are stored; the last comes from the run value
  localparam int unsigned NUM_STORED  = 3;
  localparam int unsigned SHIFT_A     = 24;
  localparam int unsigned SHIFT_B     = 16;

  typedef struct packed {
    logic [NUM_STORED-1:0][7:0] comp;
    logic [2:0]                 total;
    logic [7:0]                 run;
    logic                       seen;
    logic                       failed;
  } parse_state_t;

  typedef struct packed {
    logic        en;
    logic [31:0] address;
    logic        ok;
  } parse_result_t;

endpackage

// ===== sv/ipdp_step.sv =====
// Per-byte parse update: next parse state and the result for a final byte.
module ipdp_step (
  input  logic [7:0]             text_byte,
  input  logic                   last_byte,
  input  logic                   empty_string,
  input  ipdp_pkg::parse_state_t st,
  output ipdp_pkg::parse_state_t st_nxt,
  output ipdp_pkg::parse_result_t res
);
  import ipdp_pkg::*;

  parse_state_t tk;
  logic [11:0]  acc;
  logic         is_digit;
  logic [31:0]  addr;
  logic         ok;

  assign is_digit = text_byte inside {[ASCII_ZERO:ASCII_NINE]};
  assign acc = ({4'd0, st.run} << 3) + ({4'd0, st.run} << 1) + {8'd0, text_byte[3:0]};

  always_comb begin
    tk = st;
    if (!st.failed) begin
      if (is_digit) begin
        if (acc > 12'(OCTET_MAX)) begin
          tk.failed = 1'b1;
        end else begin
          tk.run  = acc[7:0];
          tk.seen = 1'b1;
        end
      end else if (text_byte != ASCII_DOT || last_byte || st.total >= 3'(MAX_COMP)) begin
        tk.failed = 1'b1;
      end else begin
        if (st.total < 3'(NUM_STORED)) begin
          tk.comp[st.total[1:0]] = st.seen ? st.run : 8'd0;
        end
        tk.total = st.total + 3'd1;
        tk.run   = 8'd0;
        tk.seen  = 1'b0;
      end
    end
  end

  always_comb begin
    case (tk.total)
      3'd0:    addr = {24'd0, tk.run};
      3'd1:    addr = ({24'd0, tk.comp[0]} << SHIFT_A) | {24'd0, tk.run};
      3'd2:    addr = ({24'd0, tk.comp[0]} << SHIFT_A) | ({24'd0, tk.comp[1]} << SHIFT_B)
                      | {24'd0, tk.run};
      default: addr = {tk.comp[0], tk.comp[1], tk.comp[2], tk.run};
    endcase
  end

  assign ok = !empty_string && !tk.failed && tk.seen && tk.total < 3'(MAX_COMP);

  always_comb begin
    res.en      = last_byte || empty_string;
    res.ok      = ok;
    res.address = ok ? addr : 32'd0;
    st_nxt      = res.en ? '0 : tk;
  end

endmodule

// ===== sv/ipdp_out_reg.sv =====
// Result register: holds one item for the output channel under stall.
module ipdp_out_reg (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ipdp_pkg::parse_result_t res,
  output logic                    free,
  output logic                    out_vld,
  input  logic                    out_stall,
  output logic [31:0]             out_address,
  output logic                    out_address_valid
);
  import ipdp_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] addr_r;
  logic        ok_r;
  logic        load;

  assign free      = !valid_r || !out_stall;
  assign load      = res.en && free;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= res.address;
      ok_r   <= res.ok;
    end
  end

  assign out_vld           = valid_r;
  assign out_address       = addr_r;
  assign out_address_valid = ok_r;

endmodule

// ===== sv/ipv4_dotted_text_parser.sv =====
// Top level of the dotted-decimal IPv4 text parser.
// Usage:
//   Input channel (in_valid / in_stall): one byte of the address string per
//   item, in_last_byte on the final byte; in_empty_string marks a zero-length
//   string (the byte is ignored) and also abandons any string in progress.
//   Output channel (out_vld / out_stall): one item per string, given for its
//   final byte: out_address and out_address_valid; the address is 0 when the
//   string does not parse.
//   Path: an accepted item is held in the input register; from there the
//   parse state and, for a final byte, the result register load, and
//   out_vld rises when the result register holds the result.
//   Throughput: one byte per cycle unless a final byte stalls; the parse
//   state is updated combinationally between the input and result registers.
//   Stall: when out_stall holds a waiting result, a non-final byte still
//   proceeds; a final byte waits in the input register and in_stall rises.
//   Reset: synchronous, rst_n low; clears both valid flags and the parse state.
module ipv4_dotted_text_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_last_byte,
  input  logic        in_empty_string,
  output logic        out_vld,
  input  logic        out_stall,
  output logic [31:0] out_address,
  output logic        out_address_valid
);
  import ipdp_pkg::*;

  logic          s1_v_r;
  logic          s1_v_nxt;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic          s1_empty_r;
  parse_state_t  st_r;
  parse_state_t  st_nxt;
  parse_result_t res;
  parse_result_t res_gated;
  logic          free;
  logic          s1_go;
  logic          in_take;

  ipdp_step u_step (
    .text_byte    (s1_byte_r),
    .last_byte    (s1_last_r),
    .empty_string (s1_empty_r),
    .st           (st_r),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  assign s1_go   = s1_v_r && (!res.en || free);
  assign in_stall = s1_v_r && !s1_go;
  assign in_take = in_valid && !in_stall;
  assign s1_v_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);

  always_comb begin
    res_gated    = res;
    res_gated.en = res.en && s1_v_r;
  end

  ipdp_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res_gated),
    .free              (free),
    .out_vld           (out_vld),
    .out_stall         (out_stall),
    .out_address       (out_address),
    .out_address_valid (out_address_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      st_r   <= '0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (s1_go) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_text_byte;
      s1_last_r  <= in_last_byte;
      s1_empty_r <= in_empty_string;
    end
  end

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_address_valid |-> out_address == 32'd0)
    else $error("invalid result carries a non-zero address");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.total <= 3'(MAX_COMP))
    else $error("component count out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r && res.en && out_vld && out_stall)
    else $error("input stalled without a blocked result");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_last_r || s1_empty_r) |=> st_r.total == 3'd0 && !st_r.seen && !st_r.failed)
    else $error("parse state not cleared after a final item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_last_r || s1_empty_r) |=> out_vld)
    else $error("final item gave no result");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the dotted-decimal IPv4 text parser: stimulus, address scoreboard and checks.
module tb_top;
  import ipdp_pkg::*;

  // Tracks the parse of the incoming byte stream and holds the addresses still to come out.
  class ipv4_text_scoreboard;
    typedef struct packed {
      logic [31:0] addr;
      logic        ok;
    } addr_result_t;

    logic [7:0]   octets[NUM_STORED];
    int unsigned  parts;
    logic [7:0]   cur;
    bit           have_digit;
    bit           broken;
    addr_result_t pending_addrs[$];
    int unsigned  errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      foreach (octets[i]) octets[i] = 8'h00;
      parts      = 0;
      cur        = 8'h00;
      have_digit = 1'b0;
      broken     = 1'b0;
    endfunction

    function int unsigned pending();
      return pending_addrs.size();
    endfunction

    function void note_item(logic [7:0] b, logic last, logic empty);
      int unsigned  val;
      addr_result_t res;
      // an empty mark stands for the whole string, finished or not
      if (empty) begin
        res = '0;
        pending_addrs.push_back(res);
        clear_parse();
        return;
      end
      if (!broken) begin
        if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
          val = cur * 10 + (b - ASCII_ZERO);
          if (val > OCTET_MAX) begin
            broken = 1'b1;
          end else begin
            cur        = val[7:0];
            have_digit = 1'b1;
          end
        end else if (b != ASCII_DOT || last || parts >= MAX_COMP) begin
          broken = 1'b1;
        end else begin
          // a fourth component closed by a dot is counted but never stored
          if (parts < NUM_STORED) octets[parts] = have_digit ? cur : 8'h00;
          parts++;
          cur        = 8'h00;
          have_digit = 1'b0;
        end
      end
      if (!last) return;
      res = '0;
      if (!broken && have_digit && parts < MAX_COMP) begin
        res.ok = 1'b1;
        case (parts)
          0:       res.addr = {24'h0, cur};
          1:       res.addr = {octets[0], 16'h0, cur};
          2:       res.addr = {octets[0], octets[1], 8'h0, cur};
          default: res.addr = {octets[0], octets[1], octets[2], cur};
        endcase
      end
      pending_addrs.push_back(res);
      clear_parse();
    endfunction

    function void check_result(logic [31:0] addr, logic ok);
      addr_result_t exp;
      if (pending_addrs.size() == 0) begin
        $error("unexpected result: out_address %h, out_address_valid %b", addr, ok);
        errors++;
        return;
      end
      exp = pending_addrs.pop_front();
      if (addr !== exp.addr) begin
        $error("out_address: expected %h, got %h", exp.addr, addr);
        errors++;
      end
      if (ok !== exp.ok) begin
        $error("out_address_valid: expected %b, got %b", exp.ok, ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        in_empty_string = 1'b0;
  logic        out_vld;
  logic        out_stall = 1'b0;
  logic [31:0] out_address;
  logic        out_address_valid;

  ipv4_text_scoreboard tracker = new();

  logic [7:0]  text_buf[$];
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned send_pcts[4] = '{0, 82, 0, 38};
  int unsigned recv_pcts[4] = '{0, 0, 82, 38};

  ipv4_dotted_text_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_last_byte      (in_last_byte),
    .in_empty_string   (in_empty_string),
    .out_vld           (out_vld),
    .out_stall         (out_stall),
    .out_address       (out_address),
    .out_address_valid (out_address_valid)
  );

  always #10 clk = ~clk;

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic push_item(input logic [7:0] b, input logic last, input logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_text_byte    <= b;
    in_last_byte    <= last;
    in_empty_string <= empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(b, last, empty);
    items_sent++;
    @(negedge clk);
  endtask

  // abandon: leave the string open and cut it short with an empty mark
  task automatic send_text(input bit abandon);
    int unsigned i;
    for (i = 0; i < text_buf.size(); i++)
      push_item(text_buf[i], !abandon && i == text_buf.size() - 1, 1'b0);
    if (abandon || text_buf.size() == 0)
      push_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic send_str(input string s);
    int unsigned i;
    text_buf.delete();
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text(1'b0);
  endtask

  task automatic put_number(input int unsigned n);
    if (n >= 100) text_buf.push_back(ASCII_ZERO + 8'(n / 100));
    if (n >= 10) text_buf.push_back(ASCII_ZERO + 8'((n / 10) % 10));
    text_buf.push_back(ASCII_ZERO + 8'(n % 10));
  endtask

  task automatic put_component();
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 95) return;   // no digits at all
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 3)) text_buf.push_back(ASCII_ZERO);
    if (r < 20)      put_number($urandom_range(9));
    else if (r < 40) put_number(OCTET_MAX);
    else if (r < 55) put_number(0);
    else if (r < 85) put_number($urandom_range(255));
    else             put_number($urandom_range(999, 256));
  endtask

  function automatic logic [7:0] digit_or_dot();
    int unsigned r;
    r = $urandom_range(10);
    return (r == 10) ? ASCII_DOT : ASCII_ZERO + 8'(r);
  endfunction

  task automatic build_random_text(output bit abandon);
    int unsigned kind, n, i, pos;
    text_buf.delete();
    abandon = 1'b0;
    kind = $urandom_range(99);
    if (kind < 80) begin
      n = $urandom_range(4, 1);
      if ($urandom_range(9) == 0) n = 5;
      for (i = 0; i < n; i++) begin
        if (i != 0) text_buf.push_back(ASCII_DOT);
        put_component();
      end
      if ($urandom_range(19) == 0) text_buf.push_back(ASCII_DOT);
      if (text_buf.size() == 0) text_buf.push_back(digit_or_dot());
      // a stray byte somewhere in an otherwise sane string
      if (kind >= 70) begin
        pos = $urandom_range(text_buf.size() - 1);
        text_buf[pos] = 8'($urandom_range(255));
      end
    end else if (kind < 88) begin
      n = $urandom_range(6, 1);
      repeat (n) text_buf.push_back($urandom_range(1) ? 8'($urandom_range(255)) : digit_or_dot());
    end else if (kind >= 94) begin
      n = $urandom_range(5, 1);
      repeat (n) text_buf.push_back(digit_or_dot());
      abandon = 1'b1;
    end
  endtask

  // short strings while the receiver holds off, so the block backs up
  task automatic run_backlog();
    hold_req = 64;
    repeat (40) begin
      text_buf.delete();
      put_number($urandom_range(99));
      send_text(1'b0);
    end
  endtask

  initial begin : receiver
    int unsigned hold_left, pct_now, req_now;
    hold_left = 0;
    forever begin
      @(posedge clk);
      pct_now = recv_stall_pct;
      req_now = hold_req;
      @(negedge clk);
      if (req_now != 0) begin
        hold_left = req_now;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < pct_now);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_vld && !out_stall) tracker.check_result(out_address, out_address_valid);
  end

  initial begin : stimulus
    int unsigned k, phase_end;
    bit          abandon;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_str("255.0.0.255");
    text_buf.delete();
    send_text(1'b0);
    text_buf.delete();
    text_buf.push_back(ASCII_ZERO + 8'd7);
    send_text(1'b1);
    send_str(".1");
    send_str("256");
    text_buf.delete();
    text_buf.push_back(8'hFF);
    text_buf.push_back(ASCII_ZERO + 8'd1);
    send_text(1'b0);
    send_str("1.");
    send_str(".....1");

    for (k = 0; k < 4; k++) begin
      send_idle_pct  = send_pcts[k];
      recv_stall_pct = recv_pcts[k];
      phase_end = items_sent + 220;
      if (k == 0) run_backlog();
      while (items_sent < phase_end) begin
        build_random_text(abandon);
        send_text(abandon);
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ipdp_pkg.sv
sv/ipdp_step.sv
sv/ipdp_out_reg.sv
sv/ipv4_dotted_text_parser.sv
sim/tb_top.sv
